[src/rtp_header_deframer_core_defines.svh]
// Assertion macros for the RTP header deframer.
`ifndef RTP_HEADER_DEFRAMER_CORE_DEFINES_SVH
`define RTP_HEADER_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication checked on every rising edge outside reset
`define RHD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define RHD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RHD_ASSERT_IMPL(lbl, ante, cons, msg)
`define RHD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[src/rhd_pkg.sv]
package rhd_pkg;

  // Longest packet accepted before it is flagged malformed
  localparam logic [15:0] MaxPacketBytes = 16'hFFFF;
  // Fixed RTP header length in bytes
  localparam logic [6:0]  HdrBytes       = 7'd12;
  localparam logic [1:0]  RtpVersion     = 2'b10;

  localparam logic [6:0]  FecFirstRst    = 7'd127;
  localparam logic [6:0]  FecSecondRst   = 7'd97;

  // Byte positions of the captured header fields
  localparam logic [15:0] PosFlags       = 16'd0;
  localparam logic [15:0] PosPayloadType = 16'd1;
  localparam logic [15:0] PosSeqHi       = 16'd2;
  localparam logic [15:0] PosSeqLo       = 16'd3;

  typedef enum logic [1:0] {
    StNonRtp = 2'd0,
    StRtpOk  = 2'd1,
    StFec    = 2'd2,
    StBad    = 2'd3
  } pkt_status_e;

  typedef enum logic {
    CfgFecFirst  = 1'b0,
    CfgFecSecond = 1'b1
  } cfg_idx_e;

  // Summary of one finished packet, handed from tracker to classifier
  typedef struct packed {
    logic        overflow;
    logic [16:0] len;
    logic [7:0]  flags;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [15:0] ext_words;
    logic [7:0]  last_byte;
  } rhd_pkt_t;

endpackage

[src/rhd_if.sv]
// Packet byte channel
interface rhd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// Per-packet result channel
interface rhd_out_if;
  logic                valid;
  logic                ready;
  rhd_pkg::pkt_status_e packet_status;
  logic [15:0]         payload_offset;
  logic [15:0]         payload_length;
  logic [15:0]         sequence_number;

  modport source (output valid, output packet_status, output payload_offset,
                  output payload_length, output sequence_number, input ready);
  modport sink   (input valid, input packet_status, input payload_offset,
                  input payload_length, input sequence_number, output ready);
endinterface

[src/rhd_tracker.sv]
module rhd_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_packet_i,
  input  logic            pkt_ready_i,
  output logic            pkt_valid_o,
  output rhd_pkg::rhd_pkt_t pkt_o
);

  logic [15:0] pos_q, pos_d;
  logic [7:0]  flags_q, flags_d;
  logic [6:0]  pt_q, pt_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] ext_q, ext_d;
  logic        ovf_q, ovf_d;
  logic [6:0]  ext_at;
  logic        pkt_valid_q, pkt_valid_d;
  rhd_pkg::rhd_pkt_t pkt_q, pkt_d;

  // Field capture for the byte on the input
  always_comb begin
    ext_at  = rhd_pkg::HdrBytes + {1'b0, flags_q[3:0], 2'b00};
    ovf_d   = ovf_q | (pos_q >= rhd_pkg::MaxPacketBytes);
    flags_d = flags_q;
    pt_d    = pt_q;
    seq_d   = seq_q;
    ext_d   = ext_q;
    case (pos_q)
      rhd_pkg::PosFlags:       flags_d = data_byte_i;
      rhd_pkg::PosPayloadType: pt_d    = data_byte_i[6:0];
      rhd_pkg::PosSeqHi:       seq_d   = {data_byte_i, seq_q[7:0]};
      rhd_pkg::PosSeqLo:       seq_d   = {seq_q[15:8], data_byte_i};
      default: ;
    endcase
    // extension length sits two bytes past the CSRC list
    if (pos_q == {9'd0, ext_at + 7'd2}) begin
      ext_d = {data_byte_i, ext_q[7:0]};
    end else if (pos_q == {9'd0, ext_at + 7'd3}) begin
      ext_d = {ext_q[15:8], data_byte_i};
    end
    pos_d = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
  end

  // Packet summary at the final byte
  always_comb begin
    pkt_d.overflow  = ovf_d;
    pkt_d.len       = {1'b0, pos_q} + 17'd1;
    pkt_d.flags     = flags_d;
    pkt_d.pt        = pt_d;
    pkt_d.seq       = seq_d;
    pkt_d.ext_words = ext_d;
    pkt_d.last_byte = data_byte_i;
  end

  assign pkt_valid_d = (accept_i && end_of_packet_i) ? 1'b1 :
                       (pkt_ready_i ? 1'b0 : pkt_valid_q);

  // Running state, cleared after every final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      flags_q     <= '0;
      pt_q        <= '0;
      seq_q       <= '0;
      ext_q       <= '0;
      ovf_q       <= 1'b0;
      pkt_valid_q <= 1'b0;
    end else begin
      pkt_valid_q <= pkt_valid_d;
      if (accept_i) begin
        if (end_of_packet_i) begin
          pos_q   <= '0;
          flags_q <= '0;
          pt_q    <= '0;
          seq_q   <= '0;
          ext_q   <= '0;
          ovf_q   <= 1'b0;
        end else begin
          pos_q   <= pos_d;
          flags_q <= flags_d;
          pt_q    <= pt_d;
          seq_q   <= seq_d;
          ext_q   <= ext_d;
          ovf_q   <= ovf_d;
        end
      end
    end
  end

  // Summary register, payload only
  always_ff @(posedge clk_i) begin
    if (accept_i && end_of_packet_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign pkt_valid_o = pkt_valid_q;
  assign pkt_o       = pkt_q;

endmodule

[src/rhd_classify.sv]
module rhd_classify (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pkt_valid_i,
  output logic              pkt_ready_o,
  input  rhd_pkg::rhd_pkt_t pkt_i,
  input  logic [6:0]        fec_type_first_i,
  input  logic [6:0]        fec_type_second_i,
  rhd_out_if.source         res_o
);

  logic [6:0]  base;
  logic        is_rtp;
  logic        is_fec;
  logic        ext_short;
  logic [18:0] start;
  logic [7:0]  pad;
  logic signed [20:0] plen;
  logic        bad_len;

  rhd_pkg::pkt_status_e status_d, status_q;
  logic [15:0] offset_d, offset_q;
  logic [15:0] length_d, length_q;
  logic [15:0] seq_d, seq_q;
  logic        valid_q;
  logic        load;

  // Header arithmetic
  always_comb begin
    base      = rhd_pkg::HdrBytes + {1'b0, pkt_i.flags[3:0], 2'b00};
    is_rtp    = (pkt_i.len >= {10'd0, rhd_pkg::HdrBytes}) &&
                (pkt_i.flags[7:6] == rhd_pkg::RtpVersion);
    is_fec    = (pkt_i.pt == fec_type_first_i) || (pkt_i.pt == fec_type_second_i);
    ext_short = pkt_i.flags[4] && (({10'd0, base} + 17'd4) > pkt_i.len);
    start     = pkt_i.flags[4] ?
                ({12'd0, base} + 19'd4 + {1'b0, pkt_i.ext_words, 2'b00}) :
                {12'd0, base};
    pad       = pkt_i.flags[5] ? pkt_i.last_byte : 8'd0;
    plen      = $signed({4'd0, pkt_i.len}) - $signed({2'd0, start})
                - $signed({13'd0, pad});
    bad_len   = plen[20] || (plen == 21'sd0);
  end

  // Result selection
  always_comb begin
    status_d = rhd_pkg::StNonRtp;
    offset_d = '0;
    length_d = '0;
    seq_d    = '0;
    if (pkt_i.overflow) begin
      status_d = rhd_pkg::StBad;
    end else if (is_rtp) begin
      if (is_fec) begin
        status_d = rhd_pkg::StFec;
      end else if (ext_short || bad_len) begin
        status_d = rhd_pkg::StBad;
      end else begin
        status_d = rhd_pkg::StRtpOk;
        offset_d = start[15:0];
        length_d = plen[15:0];
        seq_d    = pkt_i.seq;
      end
    end else begin
      length_d = pkt_i.len[15:0];
    end
  end

  assign pkt_ready_o = !valid_q || res_o.ready;
  assign load        = pkt_valid_i && pkt_ready_o;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pkt_ready_o) begin
      valid_q <= pkt_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      offset_q <= offset_d;
      length_q <= length_d;
      seq_q    <= seq_d;
    end
  end

  assign res_o.valid           = valid_q;
  assign res_o.packet_status   = status_q;
  assign res_o.payload_offset  = offset_q;
  assign res_o.payload_length  = length_q;
  assign res_o.sequence_number = seq_q;

endmodule

[src/rtp_header_deframer_core.sv]
// RTP header deframer.
// pkt_i carries one packet byte per request, with end_of_packet on the final
// byte. res_o carries one result per packet: status (non-RTP, RTP ok, FEC
// skipped, malformed), payload offset, payload length and sequence number.
// Bytes are taken one per cycle while pkt_i is ready, with no gaps needed between
// packets; only running counters and captured header fields are kept per packet.
// After the final byte is accepted, the result passes the packet summary
// register, then the result register.
// Throughput: one byte per cycle while not stalled, one result per cycle at most.
// When res_o stalls the result register holds and a second finished packet
// waits in the summary register; pkt_i then drops ready only while a
// finished packet cannot move on.
// The FEC payload types are written through cfg_we_i / cfg_idx_i / cfg_wdata_i;
// the user must write them only while the block is idle, which it does not enforce.
// Reset clears the per-packet state, empties both registers and sets the FEC
// types to 127 and 97.
`include "rtp_header_deframer_core_defines.svh"

module rtp_header_deframer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  rhd_in_if.sink    pkt_i,
  rhd_out_if.source res_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [6:0] cfg_wdata_i
);

  logic [6:0] fec_first_q;
  logic [6:0] fec_second_q;
  logic       accept;
  logic       pkt_valid;
  logic       pkt_ready;
  rhd_pkg::rhd_pkt_t pkt_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fec_first_q  <= rhd_pkg::FecFirstRst;
      fec_second_q <= rhd_pkg::FecSecondRst;
    end else if (cfg_we_i) begin
      case (rhd_pkg::cfg_idx_e'(cfg_idx_i))
        rhd_pkg::CfgFecFirst:  fec_first_q  <= cfg_wdata_i;
        rhd_pkg::CfgFecSecond: fec_second_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input handshake: stall only while a finished packet cannot advance
  assign pkt_i.ready = !pkt_valid || pkt_ready;
  assign accept      = pkt_i.valid && pkt_i.ready;

  rhd_tracker u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (pkt_i.data_byte),
    .end_of_packet_i (pkt_i.end_of_packet),
    .pkt_ready_i     (pkt_ready),
    .pkt_valid_o     (pkt_valid),
    .pkt_o           (pkt_sum)
  );

  rhd_classify u_classify (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pkt_valid_i       (pkt_valid),
    .pkt_ready_o       (pkt_ready),
    .pkt_i             (pkt_sum),
    .fec_type_first_i  (fec_first_q),
    .fec_type_second_i (fec_second_q),
    .res_o             (res_o)
  );

  // Checks
  `RHD_ASSERT_IMPL(a_unused_zero, res_o.valid && (res_o.packet_status != rhd_pkg::StRtpOk), (res_o.payload_offset == 16'd0) && (res_o.sequence_number == 16'd0), "offset or sequence set on a non-ok result")
  `RHD_ASSERT_IMPL(a_bad_len_zero, res_o.valid && ((res_o.packet_status == rhd_pkg::StBad) || (res_o.packet_status == rhd_pkg::StFec)), res_o.payload_length == 16'd0, "length set on a skipped or malformed result")
  `RHD_ASSERT_IMPL(a_result_source, $rose(res_o.valid), $past(pkt_valid), "result without a finished packet")
  `RHD_ASSERT_NEXT(a_summary_held, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt_sum), "finished packet lost while stalled")

endmodule

[test/testbench.sv]
module testbench;
  import rhd_pkg::*;

  localparam int unsigned HoldCycles = 300;
  localparam int unsigned CfgSettle  = 4;

  // One finished packet as seen on the result channel
  typedef struct packed {
    pkt_status_e status;
    logic [15:0] offset;
    logic [15:0] length;
    logic [15:0] seq;
  } deframe_res_t;

  // Directed packet: header bytes, total length, last byte, typed result
  typedef struct {
    logic [7:0]   hdr;
    logic [7:0]   ptb;
    logic [15:0]  seq;
    logic [15:0]  ext;
    int unsigned  len;
    logic [7:0]   tail;
    logic         known;
    deframe_res_t res;
  } pkt_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  cfg_idx_e   cfg_idx;
  logic [6:0] cfg_wdata;

  rhd_in_if  pkt_if ();
  rhd_out_if res_if ();

  rtp_header_deframer_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // Parser shadow state and FEC types
  logic [6:0]  fec_first  = FecFirstRst;
  logic [6:0]  fec_second = FecSecondRst;
  logic [15:0] byte_pos   = '0;
  logic [7:0]  hdr_seen   = '0;
  logic [6:0]  pt_seen    = '0;
  logic [15:0] seq_seen   = '0;
  logic [15:0] ext_seen   = '0;
  logic        too_long   = 1'b0;

  deframe_res_t due_results[$];
  logic [7:0]   pkt_buf[];
  pkt_row_t     dir_rows[22];
  int unsigned  mismatches = 0;
  int unsigned  stim_bytes = 0;
  logic         hold_req     = 1'b0;
  logic         src_idle_on  = 1'b1;
  logic         sink_idle_on = 1'b1;

  // Advance the shadow parser by one byte; done is set on the final byte
  task automatic parse_byte(input logic [7:0] b, input logic eop,
                            output logic done, output deframe_res_t r);
    int unsigned p, ext_at, len, start;
    longint      plen;
    logic        bad;
    p      = byte_pos;
    ext_at = 12 + 4 * hdr_seen[3:0];
    done   = eop;
    r      = '0;
    if (p >= MaxPacketBytes) too_long = 1'b1;
    case (p)
      0:       hdr_seen = b;
      1:       pt_seen = b[6:0];
      2:       seq_seen[15:8] = b;
      3:       seq_seen[7:0] = b;
      default: ;
    endcase
    if (p >= 12 && p == ext_at + 2) ext_seen[15:8] = b;
    else if (p >= 12 && p == ext_at + 3) ext_seen[7:0] = b;
    if (!eop) begin
      if (byte_pos != 16'hFFFF) byte_pos++;
      return;
    end
    len = p + 1;
    if (too_long) begin
      r.status = StBad;
    end else if (len >= 12 && hdr_seen[7:6] == RtpVersion) begin
      if (pt_seen == fec_first || pt_seen == fec_second) begin
        r.status = StFec;
      end else begin
        start = 12 + 4 * hdr_seen[3:0];
        bad   = 1'b0;
        if (hdr_seen[4]) begin
          if (start + 4 > len) bad = 1'b1;
          else start = start + 4 + 4 * ext_seen;
        end
        plen = longint'(len) - longint'(start);
        if (hdr_seen[5]) plen = plen - longint'(b);
        if (bad || plen <= 0) begin
          r.status = StBad;
        end else begin
          r.status = StRtpOk;
          r.offset = 16'(start);
          r.length = 16'(plen);
          r.seq    = seq_seen;
        end
      end
    end else begin
      r.status = StNonRtp;
      r.length = 16'(len);
    end
    // per-packet state is cleared after the final byte
    byte_pos = '0;
    hdr_seen = '0;
    pt_seen  = '0;
    seq_seen = '0;
    ext_seen = '0;
    too_long = 1'b0;
  endtask

  // Build a packet in pkt_buf with the given header fields and last byte
  task automatic fill_packet(input logic [7:0] hdr, input logic [7:0] ptb,
                             input logic [15:0] seq, input logic [15:0] ext,
                             input int unsigned len, input logic [7:0] tail);
    int unsigned ext_at;
    ext_at  = 12 + 4 * hdr[3:0];
    pkt_buf = new[len];
    foreach (pkt_buf[i]) pkt_buf[i] = 8'($urandom);
    pkt_buf[0] = hdr;
    if (len > 1) pkt_buf[1] = ptb;
    if (len > 2) pkt_buf[2] = seq[15:8];
    if (len > 3) pkt_buf[3] = seq[7:0];
    if (len > ext_at + 2) pkt_buf[ext_at + 2] = ext[15:8];
    if (len > ext_at + 3) pkt_buf[ext_at + 3] = ext[7:0];
    pkt_buf[len - 1] = tail;
  endtask

  // Offer pkt_buf byte by byte; valid stays high after the last request unless a random gap follows
  task automatic send_packet(input logic known, input deframe_res_t typed);
    logic         done;
    deframe_res_t r;
    int unsigned  n;
    n = pkt_buf.size();
    for (int unsigned i = 0; i < n; i++) begin
      pkt_if.valid         <= 1'b1;
      pkt_if.data_byte     <= pkt_buf[i];
      pkt_if.end_of_packet <= (i == n - 1);
      do @(posedge clk_i); while (!pkt_if.ready);
      parse_byte(pkt_buf[i], i == n - 1, done, r);
      if (done) due_results.push_back(known ? typed : r);
      stim_bytes++;
      // no gaps inside the very long packets, to keep the run short
      if (src_idle_on && n <= 4096 && $urandom_range(0, 7) == 0) begin
        pkt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  // Mostly well-formed RTP with random content, the rest noise
  task automatic random_packet();
    int unsigned cc, pay, padn, len;
    logic [6:0]  pt;
    logic [7:0]  hdr, ptb, tail;
    logic [15:0] ext;
    logic        pad, xb;
    if ($urandom_range(0, 9) < 7) begin
      pad = 1'($urandom);
      xb  = 1'($urandom);
      cc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      hdr = {RtpVersion, pad, xb, 4'(cc)};
      case ($urandom_range(0, 7))
        0, 1:    pt = fec_first;
        2:       pt = fec_second;
        default: pt = 7'($urandom);
      endcase
      ptb  = {1'($urandom), pt};
      ext  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      pay  = $urandom_range(0, 24);
      padn = pad ? $urandom_range(0, 8) : 0;
      tail = pad ? 8'(padn) : 8'($urandom);
      len  = 12 + 4 * cc + (xb ? 4 + 4 * ext : 0) + pay + padn;
      // broken lengths: truncated headers and extensions
      if (len > 600 || $urandom_range(0, 7) == 0) len = $urandom_range(1, 12 + 4 * cc + 30);
    end else begin
      hdr  = 8'($urandom);
      ptb  = 8'($urandom);
      ext  = 16'($urandom);
      tail = 8'($urandom);
      len  = $urandom_range(1, 40);
    end
    fill_packet(hdr, ptb, 16'($urandom), ext, len, tail);
    send_packet(1'b0, '0);
  endtask

  task automatic random_phase(input int unsigned nbytes);
    int unsigned start;
    start = stim_bytes;
    while (stim_bytes - start < nbytes) random_packet();
    pkt_if.valid <= 1'b0;
  endtask

  // Wait for the block to go idle, then load both FEC types
  task automatic set_fec(input logic [6:0] first, input logic [6:0] second);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgFecFirst;
    cfg_wdata <= first;
    @(posedge clk_i);
    cfg_idx   <= CfgFecSecond;
    cfg_wdata <= second;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    fec_first  = first;
    fec_second = second;
  endtask

  task automatic log_mismatch(input string what, input deframe_res_t want,
                              input deframe_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: exp st=%0d off=%0d len=%0d seq=%04h, got st=%0d off=%0d len=%0d seq=%04h",
               what, want.status, want.offset, want.length, want.seq,
               got.status, got.offset, got.length, got.seq);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    deframe_res_t seen, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = {res_if.packet_status, res_if.payload_offset,
              res_if.payload_length, res_if.sequence_number};
      if (due_results.size() == 0) begin
        log_mismatch("unexpected result", '0, seen);
      end else begin
        want = due_results.pop_front();
        if (seen.status !== want.status || seen.offset !== want.offset ||
            seen.length !== want.length || seen.seq !== want.seq)
          log_mismatch("result mismatch", want, seen);
      end
    end
  end

  // Result side: random back-pressure plus one long hold on request
  initial begin : result_sink
    int unsigned hold_left, gap_left;
    hold_left    = 0;
    gap_left     = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
      end
    end
  end

  initial begin : stimulus
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = CfgFecFirst;
    cfg_wdata            = '0;
    pkt_if.valid         = 1'b0;
    pkt_if.data_byte     = '0;
    pkt_if.end_of_packet = 1'b0;

    // hdr, ptb, seq, ext, len, last byte, typed?, expected result
    dir_rows = '{
      '{8'h80, 8'h00, 16'h0000, 16'h0000, 1,     8'h80, 1'b1, '{StNonRtp, 16'd0, 16'd1, 16'h0}},
      '{8'h80, 8'h05, 16'h1234, 16'h0000, 11,    8'hFF, 1'b1, '{StNonRtp, 16'd0, 16'd11, 16'h0}},
      '{8'h80, 8'h00, 16'h1234, 16'h0000, 12,    8'h00, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}},
      '{8'h80, 8'h05, 16'hABCD, 16'h0000, 13,    8'hFF, 1'b1, '{StRtpOk, 16'd12, 16'd1, 16'hABCD}},
      '{8'h40, 8'h05, 16'h1111, 16'h0000, 20,    8'h00, 1'b1, '{StNonRtp, 16'd0, 16'd20, 16'h0}},
      '{8'hC0, 8'h05, 16'h1111, 16'h0000, 20,    8'h00, 1'b1, '{StNonRtp, 16'd0, 16'd20, 16'h0}},
      '{8'h00, 8'h05, 16'h1111, 16'h0000, 20,    8'h00, 1'b1, '{StNonRtp, 16'd0, 16'd20, 16'h0}},
      '{8'h80, 8'hFF, 16'h2222, 16'h0000, 30,    8'h55, 1'b1, '{StFec, 16'd0, 16'd0, 16'h0}},
      '{8'h80, 8'hE1, 16'h2222, 16'h0000, 30,    8'h55, 1'b1, '{StFec, 16'd0, 16'd0, 16'h0}},
      '{8'h90, 8'h7F, 16'h2222, 16'h0000, 12,    8'h00, 1'b1, '{StFec, 16'd0, 16'd0, 16'h0}},
      '{8'h90, 8'h05, 16'h3333, 16'h0000, 15,    8'h00, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}},
      '{8'h90, 8'h05, 16'h0000, 16'h0001, 24,    8'hAA, 1'b1, '{StRtpOk, 16'd20, 16'd4, 16'h0}},
      '{8'h9F, 8'h05, 16'h4444, 16'hFFFF, 100,   8'h00, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}},
      '{8'h8F, 8'h05, 16'h5555, 16'h0000, 73,    8'h00, 1'b1, '{StRtpOk, 16'd72, 16'd1, 16'h5555}},
      '{8'hA0, 8'h05, 16'h6666, 16'h0000, 20,    8'h03, 1'b1, '{StRtpOk, 16'd12, 16'd5, 16'h6666}},
      '{8'hA0, 8'h05, 16'h6666, 16'h0000, 20,    8'hFF, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}},
      '{8'hA0, 8'h05, 16'h6666, 16'h0000, 20,    8'h08, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}},
      '{8'hBF, 8'h85, 16'h7777, 16'h0010, 200,   8'h10, 1'b0, '0},
      '{8'hB2, 8'h0A, 16'h8888, 16'h0002, 40,    8'h02, 1'b0, '0},
      '{8'h80, 8'h60, 16'h0102, 16'h0000, 14,    8'h00, 1'b1, '{StRtpOk, 16'd12, 16'd2, 16'h0102}},
      '{8'h80, 8'h00, 16'hFFFF, 16'h0000, 65535, 8'h00, 1'b1,
        '{StRtpOk, 16'd12, 16'd65523, 16'hFFFF}},
      '{8'h80, 8'h00, 16'hFFFF, 16'h0000, 65537, 8'h00, 1'b1, '{StBad, 16'd0, 16'd0, 16'h0}}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets at the reset FEC types
    foreach (dir_rows[k]) begin
      fill_packet(dir_rows[k].hdr, dir_rows[k].ptb, dir_rows[k].seq, dir_rows[k].ext,
                  dir_rows[k].len, dir_rows[k].tail);
      send_packet(dir_rows[k].known, dir_rows[k].res);
    end
    pkt_if.valid <= 1'b0;

    // long result stall while one-byte packets keep coming
    set_fec(7'd0, 7'd0);
    src_idle_on = 1'b0;
    hold_req    = 1'b1;
    repeat (40) begin
      pkt_buf    = new[1];
      pkt_buf[0] = 8'($urandom);
      send_packet(1'b0, '0);
    end
    pkt_if.valid <= 1'b0;
    src_idle_on = 1'b1;

    random_phase(270);
    set_fec(7'd127, 7'd127);
    random_phase(270);
    set_fec(7'($urandom), 7'($urandom));
    random_phase(270);
    set_fec(7'd5, 7'd0);
    random_phase(270);

    // last stretch runs without idling on either side
    set_fec(7'($urandom), 7'd127);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    random_phase(270);

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
